[hw/rtl/srpg_pkg.sv]
// ----------------------------------------------------------------------------
// srpg_pkg
// Shared types and constants for the stepper ramp pulse generator.
// ----------------------------------------------------------------------------
package srpg_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int WORD_W      = 32;
    localparam int CMD_W       = 2;
    localparam int TADDR_W     = 8;
    // wide enough to hold both a table address and the table depth itself
    localparam int AWIDE_W     = ((IDX_W > TADDR_W) ? IDX_W : TADDR_W) + 1;

    localparam logic [WORD_W-1:0] CUR_TICKS_RESET = WORD_W'(200000 / 2);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_LOAD  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        PH_STOPPED  = 2'd0,
        PH_RAMPING  = 2'd1,
        PH_AT_SPEED = 2'd2
    } t_ramp_phase;

    typedef struct packed {
        logic step_pin;
        logic current_pin;
        logic running;
        logic at_speed;
    } t_result;

endpackage

[hw/rtl/stepper_ramp_pulse_generator.sv]
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator
// Step pulse generator with a table-driven acceleration ramp and a current
// chopping square wave.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------------
//  in       | sink      | i_in_valid / o_in_stall   | i_command, i_value,
//           |           |                           | i_table_address
//  out      | source    | o_out_valid / i_out_stall | o_step_pin, o_current_pin,
//           |           |                           | o_running, o_at_speed
//  cfg      | sink      | i_cfg_valid / o_cfg_ready | i_cfg_data (current_toggle_ticks)
//
//  One item per clock while o_in_stall is low; each item gives one registered result.
//  The ramp table RAM is read every cycle at the next ramp index, so the word for the
//  next ramp fetch is already waiting when a rising step edge comes; entry 0 is shadowed
//  in a register for the start command.
//  Synchronous active-low reset clears all control state; the table stays undefined
//  until loaded and needs no clearing pass.
//  An output register plus one skid entry absorb a stall; o_in_stall rises only when
//  both are full.
//
module stepper_ramp_pulse_generator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input items
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [srpg_pkg::CMD_W-1:0]   i_command,
    input  logic [srpg_pkg::WORD_W-1:0]  i_value,
    input  logic [srpg_pkg::TADDR_W-1:0] i_table_address,
    // results
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_step_pin,
    output logic                         o_current_pin,
    output logic                         o_running,
    output logic                         o_at_speed,
    // configuration
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [srpg_pkg::WORD_W-1:0]  i_cfg_data
);
    import srpg_pkg::*;

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] r_timer,       n_timer;
    logic [WORD_W-1:0] r_step_mark,   n_step_mark;
    logic [WORD_W-1:0] r_cur_mark,    n_cur_mark;
    logic [WORD_W-1:0] r_step_period, n_step_period;
    logic [WORD_W-1:0] r_target,      n_target;
    logic [IDX_W-1:0]  r_ramp_index,  n_ramp_index;
    t_ramp_phase       r_phase,       n_phase;
    logic              r_run,         n_run;
    logic              r_step_phase,  n_step_phase;
    logic              r_cur_phase,   n_cur_phase;
    logic              r_step_level,  n_step_level;
    logic              r_cur_level,   n_cur_level;
    logic [WORD_W-1:0] r_cur_ticks;
    logic [WORD_W-1:0] r_entry0;

    // forwarding of a load that hits the entry being read in the same cycle
    logic              r_fwd_valid;
    logic [WORD_W-1:0] r_fwd_data;

    // output register and skid entry
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    logic                accept;
    logic                out_fire;
    t_cmd                cmd;
    logic [AWIDE_W-1:0]  addr_wide;
    logic                load_we;
    logic [IDX_W-1:0]    load_addr;
    logic [WORD_W-1:0]   ram_rdata;
    logic [WORD_W-1:0]   next_word;
    logic [WORD_W-1:0]   fetch_word;
    logic                do_advance;
    logic [WORD_W-1:0]   adv_target;
    logic [WORD_W-1:0]   step_elapsed;
    logic [WORD_W-1:0]   cur_elapsed;
    t_result             result;

    assign accept     = i_in_valid && !r_skid_valid;
    assign out_fire   = r_out_valid && !i_out_stall;
    assign cmd        = t_cmd'(i_command);
    assign addr_wide  = AWIDE_W'(i_table_address);
    assign load_we    = accept && (cmd == CMD_LOAD) && (addr_wide < AWIDE_W'(TABLE_DEPTH));
    assign load_addr  = addr_wide[IDX_W-1:0];

    // word at r_ramp_index as the table holds it now
    assign next_word  = r_fwd_valid ? r_fwd_data : ram_rdata;

    // ------------------------------------------------------------------
    // Ramp table: read ahead at the index the next cycle will use
    // ------------------------------------------------------------------
    srpg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ramp_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (load_addr),
        .i_wdata (i_value),
        .i_raddr (n_ramp_index),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Next state for one item
    // ------------------------------------------------------------------
    always_comb begin
        n_timer       = r_timer;
        n_step_mark   = r_step_mark;
        n_cur_mark    = r_cur_mark;
        n_step_period = r_step_period;
        n_target      = r_target;
        n_ramp_index  = r_ramp_index;
        n_phase       = r_phase;
        n_run         = r_run;
        n_step_phase  = r_step_phase;
        n_cur_phase   = r_cur_phase;
        n_step_level  = r_step_level;
        n_cur_level   = r_cur_level;
        do_advance    = 1'b0;
        fetch_word    = next_word;
        adv_target    = r_target;
        step_elapsed  = r_timer + WORD_W'(1) - r_step_mark;
        cur_elapsed   = r_timer + WORD_W'(1) - r_cur_mark;

        if (accept) begin
            case (cmd)
                CMD_TICK: begin
                    n_timer = r_timer + WORD_W'(1);
                    if (r_run) begin
                        if (step_elapsed >= (r_step_period >> 1)) begin
                            if (r_step_phase) begin
                                // rising edge: fetch the next ramp period
                                do_advance   = (r_phase == PH_RAMPING);
                                n_step_level = 1'b1;
                            end else begin
                                n_step_level = 1'b0;
                            end
                            n_step_phase = !r_step_phase;
                            n_step_mark  = n_timer;
                        end
                        if (cur_elapsed >= r_cur_ticks) begin
                            n_cur_level = r_cur_phase;
                            n_cur_phase = !r_cur_phase;
                            n_cur_mark  = n_timer;
                        end
                    end
                end
                CMD_START: begin
                    // restart the ramp from entry 0; current timing keeps going
                    n_target     = i_value;
                    adv_target   = i_value;
                    n_ramp_index = '0;
                    n_phase      = PH_RAMPING;
                    n_run        = 1'b1;
                    n_step_mark  = r_timer;
                    n_step_phase = 1'b0;
                    fetch_word   = r_entry0;
                    do_advance   = 1'b1;
                end
                CMD_STOP: begin
                    n_run = 1'b0;
                end
                default: begin
                    // table load: handled by the RAM write port
                end
            endcase

            if (do_advance) begin
                n_step_period = fetch_word;
                if (n_ramp_index < IDX_W'(TABLE_DEPTH - 1)) begin
                    n_ramp_index = n_ramp_index + IDX_W'(1);
                end
                if (fetch_word < adv_target) begin
                    n_step_period = adv_target;
                    n_phase       = PH_AT_SPEED;
                end
            end
        end

        result.step_pin    = n_step_level;
        result.current_pin = n_cur_level;
        result.running     = n_run;
        result.at_speed    = (n_phase == PH_AT_SPEED);
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer       <= '0;
            r_step_mark   <= '0;
            r_cur_mark    <= '0;
            r_step_period <= '0;
            r_target      <= '0;
            r_ramp_index  <= '0;
            r_phase       <= PH_STOPPED;
            r_run         <= 1'b0;
            r_step_phase  <= 1'b0;
            r_cur_phase   <= 1'b0;
            r_step_level  <= 1'b0;
            r_cur_level   <= 1'b0;
            r_cur_ticks   <= CUR_TICKS_RESET;
            r_fwd_valid   <= 1'b0;
        end else begin
            r_timer       <= n_timer;
            r_step_mark   <= n_step_mark;
            r_cur_mark    <= n_cur_mark;
            r_step_period <= n_step_period;
            r_target      <= n_target;
            r_ramp_index  <= n_ramp_index;
            r_phase       <= n_phase;
            r_run         <= n_run;
            r_step_phase  <= n_step_phase;
            r_cur_phase   <= n_cur_phase;
            r_step_level  <= n_step_level;
            r_cur_level   <= n_cur_level;
            if (i_cfg_valid) begin
                r_cur_ticks <= i_cfg_data;
            end
            // RAM read returns the old word when the same entry is written
            r_fwd_valid   <= load_we && (load_addr == n_ramp_index);
        end
    end

    // payload registers: shadow of entry 0 and forwarded load data
    always_ff @(posedge i_clk) begin
        r_fwd_data <= i_value;
        if (load_we && (load_addr == '0)) begin
            r_entry0 <= i_value;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid entry
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                // no transfer in: drain the skid entry when the output moves
                if (out_fire) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (accept) begin
                if (!r_out_valid || out_fire) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            if (!r_out_valid || out_fire) begin
                r_out <= result;
            end else begin
                r_skid <= result;
            end
        end
    end

    assign o_in_stall    = r_skid_valid;
    assign o_out_valid   = r_out_valid;
    assign o_step_pin    = r_out.step_pin;
    assign o_current_pin = r_out.current_pin;
    assign o_running     = r_out.running;
    assign o_at_speed    = r_out.at_speed;
    assign o_cfg_ready   = 1'b1;

endmodule

[hw/rtl/srpg_ram.sv]
// ----------------------------------------------------------------------------
// srpg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srpg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/srpg_checker.sv]
// ----------------------------------------------------------------------------
// srpg_assertions
// Port-level checks for the stepper ramp pulse generator.
// ----------------------------------------------------------------------------
module srpg_assertions (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_step_pin,
    input logic o_current_pin,
    input logic o_running,
    input logic o_at_speed
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_step_pin) && $stable(o_current_pin)
            && $stable(o_running) && $stable(o_at_speed))
        else $error("stalled result changed");

    // input stalls only once a transfer met a stalled full output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && o_out_valid && i_out_stall))
        else $error("input stall without output backpressure");

    // reset leaves no result and no stall behind
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind stepper_ramp_pulse_generator srpg_assertions u_srpg_assertions (.*);

[sim/srpg_checker.sv]
// ----------------------------------------------------------------------------
// srpg_checker
// Watches the item, result and register channels of the stepper ramp pulse
// generator. Keeps its own copy of the step timer, ramp table and pin state,
// computes the pin levels due for every input transfer and compares them with
// the result transfers in order.
// ----------------------------------------------------------------------------
module srpg_checker
    import srpg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [WORD_W-1:0]  i_value,
    input  logic [TADDR_W-1:0] i_table_address,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_step_pin,
    input  logic               i_current_pin,
    input  logic               i_running,
    input  logic               i_at_speed,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [WORD_W-1:0]  i_cfg_data,
    output int                 o_failures,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [WORD_W-1:0] ramp_words [TABLE_DEPTH];
    logic [WORD_W-1:0] timer;
    logic [WORD_W-1:0] step_mark;
    logic [WORD_W-1:0] cur_mark;
    logic [WORD_W-1:0] step_period;
    logic [WORD_W-1:0] target_period;
    logic [WORD_W-1:0] toggle_ticks;
    logic [IDX_W-1:0]  ramp_idx;
    t_ramp_phase       ramp_phase;
    logic              run_flag;
    logic              step_ph;
    logic              cur_ph;
    logic              step_lvl;
    logic              cur_lvl;
    t_result           pin_levels_due [$];
    int                failures = 0;

    initial begin
        o_failures = 0;
        o_pending  = 0;
    end

    // Fetch the next period while ramping; hold the target once it is undercut.
    function automatic void fetch_ramp_word();
        if (ramp_phase != PH_RAMPING) return;
        step_period = ramp_words[ramp_idx];
        if (int'(ramp_idx) < TABLE_DEPTH - 1) ramp_idx = ramp_idx + 1'b1;
        if (step_period < target_period) begin
            step_period = target_period;
            ramp_phase  = PH_AT_SPEED;
        end
    endfunction

    function automatic void advance_timer();
        logic [WORD_W-1:0] elapsed;
        timer = timer + 1'b1;
        if (!run_flag) return;
        elapsed = timer - step_mark;
        if (elapsed >= (step_period >> 1)) begin
            if (!step_ph) begin
                step_lvl = 1'b0;
            end else begin
                fetch_ramp_word();
                step_lvl = 1'b1;
            end
            step_ph   = ~step_ph;
            step_mark = timer;
        end
        elapsed = timer - cur_mark;
        if (elapsed >= toggle_ticks) begin
            cur_lvl  = cur_ph;
            cur_ph   = ~cur_ph;
            cur_mark = timer;
        end
    endfunction

    function automatic t_result pin_levels_after(input t_cmd cmd,
                                                 input logic [WORD_W-1:0] val,
                                                 input logic [TADDR_W-1:0] addr);
        t_result levels;
        case (cmd)
            CMD_TICK: begin
                advance_timer();
            end
            CMD_START: begin
                target_period = val;
                ramp_idx      = '0;
                ramp_phase    = PH_RAMPING;
                run_flag      = 1'b1;
                step_mark     = timer;
                step_ph       = 1'b0;
                fetch_ramp_word();
            end
            CMD_STOP: begin
                run_flag = 1'b0;
            end
            default: begin
                if (int'(addr) < TABLE_DEPTH) ramp_words[addr] = val;
            end
        endcase
        levels.step_pin    = step_lvl;
        levels.current_pin = cur_lvl;
        levels.running     = run_flag;
        levels.at_speed    = (ramp_phase == PH_AT_SPEED);
        return levels;
    endfunction

    function automatic int pin_differs(input string name, input logic want, input logic got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            timer         = '0;
            step_mark     = '0;
            cur_mark      = '0;
            step_period   = '0;
            target_period = '0;
            toggle_ticks  = CUR_TICKS_RESET;
            ramp_idx      = '0;
            ramp_phase    = PH_STOPPED;
            run_flag      = 1'b0;
            step_ph       = 1'b0;
            cur_ph        = 1'b0;
            step_lvl      = 1'b0;
            cur_lvl       = 1'b0;
            pin_levels_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pin_levels_due.size() == 0) begin
                    $display("%0t: result with none expected, expected none, actual %b%b%b%b",
                             $time, i_step_pin, i_current_pin, i_running, i_at_speed);
                    failures++;
                end else begin
                    want = pin_levels_due.pop_front();
                    failures += pin_differs("step_pin", want.step_pin, i_step_pin)
                              + pin_differs("current_pin", want.current_pin, i_current_pin)
                              + pin_differs("running", want.running, i_running)
                              + pin_differs("at_speed", want.at_speed, i_at_speed);
                end
            end
            if (i_cfg_valid && i_cfg_ready) toggle_ticks = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                pin_levels_due.push_back(pin_levels_after(t_cmd'(i_command), i_value,
                                                          i_table_address));
        end
        o_failures <= failures;
        o_pending  <= pin_levels_due.size();
    end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the stepper ramp pulse generator. Runs a directed
// opening, fills the ramp table with an acceleration profile, ramps to the
// table end, then random command sequences under several chopping intervals,
// with random gaps and stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import srpg_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int HOLD_CYCLES  = 80;
    localparam int IDLE_PCT     = 27;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int CHUNK_ITEMS  = 230;

    logic               clk             = 1'b0;
    logic               rst_n           = 1'b0;
    logic               in_valid        = 1'b0;
    logic               in_stall;
    logic [CMD_W-1:0]   in_command      = CMD_TICK;
    logic [WORD_W-1:0]  in_value        = '0;
    logic [TADDR_W-1:0] in_table_address = '0;
    logic               out_valid;
    logic               out_stall       = 1'b0;
    logic               step_pin;
    logic               current_pin;
    logic               running;
    logic               at_speed;
    logic               cfg_valid       = 1'b0;
    logic               cfg_ready;
    logic [WORD_W-1:0]  cfg_data        = '0;

    int failures;
    int pending;
    int cycles        = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    bit calm          = 1'b0;   // no random gaps or stalls while set

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stepper_ramp_pulse_generator u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_command       (in_command),
        .i_value         (in_value),
        .i_table_address (in_table_address),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_step_pin      (step_pin),
        .o_current_pin   (current_pin),
        .o_running       (running),
        .o_at_speed      (at_speed),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    srpg_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_command       (in_command),
        .i_value         (in_value),
        .i_table_address (in_table_address),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_step_pin      (step_pin),
        .i_current_pin   (current_pin),
        .i_running       (running),
        .i_at_speed      (at_speed),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_failures      (failures),
        .o_pending       (pending)
    );

    // Abort a hung run.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result receiver: random stalls, or a long hold-off when one is requested.
    // The hold-off is counted here so the sender keeps offering items meanwhile.
    always begin
        @(negedge clk);
        if (hold_requests != holds_served) begin
            out_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clk);
            holds_served++;
        end else begin
            out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Offer one item, with random gaps ahead of it, and hold it until transfer.
    task automatic send_item(input t_cmd cmd, input logic [WORD_W-1:0] val,
                             input logic [TADDR_W-1:0] addr);
        @(negedge clk);
        while (!calm && ($urandom_range(0, 99) < IDLE_PCT)) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid         <= 1'b1;
        in_command       <= cmd;
        in_value         <= val;
        in_table_address <= addr;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(CMD_TICK, $urandom, TADDR_W'($urandom));
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_toggle_ticks(input logic [WORD_W-1:0] ticks);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly complete moves (reload a few ramp words, start, step, maybe stop),
    // the rest raw commands with random payload.
    task automatic random_chunk(input int n_items);
        int            done;
        int            loads;
        int            roll;
        int            steps;
        logic [WORD_W-1:0] target;
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(0, 99) < 70) begin
                loads = $urandom_range(0, 3);
                repeat (loads) begin
                    if ($urandom_range(0, 19) == 0)
                        send_item(CMD_LOAD, $urandom, TADDR_W'($urandom));
                    else
                        send_item(CMD_LOAD, WORD_W'($urandom_range(0, 12)),
                                  TADDR_W'($urandom));
                end
                roll = $urandom_range(0, 9);
                if (roll == 0)      target = $urandom;
                else if (roll == 1) target = '0;
                else                target = WORD_W'($urandom_range(1, 10));
                send_item(CMD_START, target, TADDR_W'($urandom));
                steps = $urandom_range(10, 60);
                send_ticks(steps);
                done += loads + 1 + steps;
                if ($urandom_range(0, 1) == 1) begin
                    steps = $urandom_range(0, 4);
                    send_item(CMD_STOP, $urandom, TADDR_W'($urandom));
                    send_ticks(steps);
                    done += 1 + steps;
                end
            end else begin
                send_item(t_cmd'($urandom_range(0, 3)), $urandom, TADDR_W'($urandom));
                done++;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening under the reset chopping interval. Only entry 0 of
        // the ramp table is read here: every start undercuts it at once.
        send_item(CMD_TICK, 32'hFFFF_FFFF, 8'hFF);    // tick while stopped
        send_item(CMD_TICK, 32'h0, 8'h00);
        send_item(CMD_STOP, $urandom, 8'h5A);         // stop while already stopped
        send_item(CMD_LOAD, 32'hFFFF_FFFF, 8'hFF);    // last entry, widest word
        send_item(CMD_LOAD, 32'h0, 8'h00);
        send_item(CMD_START, 32'hFFFF_FFFF, 8'h00);   // widest target, at speed at once
        send_ticks(2);
        send_item(CMD_STOP, 32'h0, 8'h00);
        send_ticks(1);
        send_item(CMD_LOAD, 32'd5, 8'h00);
        send_item(CMD_START, 32'd6, 8'h00);           // period 6: toggle every 3 ticks
        send_ticks(8);
        send_item(CMD_START, 32'd6, 8'h00);           // restart while running
        send_ticks(2);
        send_item(CMD_STOP, 32'h0, 8'hFF);            // pins hold their levels

        // Fill the whole table with a short descending acceleration profile.
        write_toggle_ticks(32'd1);
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(CMD_LOAD, WORD_W'(((TABLE_DEPTH - 1 - i) >> 6) + $urandom_range(0, 1)),
                      TADDR_W'(i));

        // Target zero is never undercut: ramp through to the table end and keep
        // fetching the last entry. Run this stretch without gaps or stalls.
        write_toggle_ticks(32'd3);
        calm = 1'b1;
        send_item(CMD_START, 32'h0, 8'h00);
        send_ticks(760);
        calm = 1'b0;

        write_toggle_ticks(32'hFFFF_FFFF);
        random_chunk(CHUNK_ITEMS);

        // Hold off the receiver while items keep coming, so the block backs up.
        write_toggle_ticks(32'h0);
        hold_requests++;
        random_chunk(CHUNK_ITEMS);

        write_toggle_ticks(WORD_W'($urandom_range(2, 40)));
        random_chunk(CHUNK_ITEMS);

        write_toggle_ticks(32'd1);
        random_chunk(CHUNK_ITEMS);

        wait_idle();
        repeat (10) @(negedge clk);
        if (failures == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
